[sv/pmu_pkg.sv]
// Package for the particle motion update unit: shared types, register codes,
// reset values, pipeline depths and saturating fixed-point helpers.
// No dependencies.
package pmu_pkg;

  // Three Q16.16 components, index 0 is x.
  typedef logic [2:0][31:0] vec3_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_CENTER_Z      = 3'd2,
    REG_DECAY_FACTOR  = 3'd3,
    REG_TAIL_LENGTH   = 3'd4,
    REG_PULL_RADIUS   = 3'd5,
    REG_PULL_STRENGTH = 3'd6
  } cfg_reg_e;

  // Reset values of the configuration registers.
  localparam logic [16:0] DECAY_RESET    = 17'd64881;
  localparam logic [30:0] TAIL_RESET     = 31'd16384;
  localparam logic [30:0] RADIUS_RESET   = 31'd19660800;
  localparam logic [31:0] STRENGTH_RESET = 32'd429497;

  // Depth of the square root and divider pipelines (one step per stage).
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;

  localparam logic signed [35:0] S32_MAX = 36'sd2147483647;
  localparam logic signed [35:0] S32_MIN = -36'sd2147483648;

  // Magnitude of a two's complement word, as an unsigned word.
  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  // Sign extension to the working width of the adders.
  function automatic logic signed [35:0] sx36(input logic [31:0] x);
    return $signed({{4{x[31]}}, x});
  endfunction

  // Magnitude with a sign attached.
  function automatic logic signed [35:0] signed_mag(input logic neg, input logic [32:0] m);
    logic signed [35:0] e;
    e = $signed({3'b000, m});
    return neg ? -e : e;
  endfunction

  // Saturation to 32 bits signed.
  function automatic logic [31:0] sat32(input logic signed [35:0] x);
    logic [31:0] r;
    if (x > S32_MAX) begin
      r = 32'h7fff_ffff;
    end else if (x < S32_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[sv/particle_motion_update_unit.sv]
// Particle motion update unit: center pull, acceleration, speed clamp, move,
// tail point and velocity decay. Depends on pmu_pkg, pmu_sqrt and pmu_div.
//
// Usage:
// - Item channel (item_valid/item_stall) takes one particle per transaction.
//   Result channel (result_valid/result_stall) returns one result per particle
//   in order.
// - Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   seven registers; cfg_ready is always high. Write only while the block is
//   empty. Indexes beyond the register list are ignored.
// - The result path runs through two 32-stage square roots and two 32-stage
//   dividers in series.
// - Throughput is one particle per cycle; the whole pipeline advances
//   together whenever the result register is empty or being taken.
// - When the receiver stalls with a result waiting, every stage holds and
//   item_stall rises in the same cycle; nothing is dropped or repeated.
// - Reset clears all valid bits and loads the register defaults: center at
//   the origin, decay 0.99, tail 0.25, pull radius 300, pull gain 0.0001.
module particle_motion_update_unit import pmu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic signed [31:0] acc_x,
  input  logic signed [31:0] acc_y,
  input  logic signed [31:0] acc_z,
  input  logic [19:0] speed_max,
  input  logic [19:0] speed_min,
  input  logic        flatten,
  output logic        result_valid,
  input  logic        result_stall,
  output logic signed [31:0] new_pos_x,
  output logic signed [31:0] new_pos_y,
  output logic signed [31:0] new_pos_z,
  output logic signed [31:0] new_vel_x,
  output logic signed [31:0] new_vel_y,
  output logic signed [31:0] new_vel_z,
  output logic signed [31:0] tail_x,
  output logic signed [31:0] tail_y,
  output logic signed [31:0] tail_z
);

  typedef struct packed {
    logic        vld;
    vec3_t       p;
    vec3_t       v;
    vec3_t       a;
    logic [19:0] smax;
    logic [19:0] smin;
    logic        flat;
  } base_t;

  typedef struct packed {
    base_t       b;
    vec3_t       dmag;
    logic [2:0]  dneg;
  } dl1_t;

  typedef struct packed {
    base_t       b;
    logic [2:0]  dneg;
    logic        pull;
  } dl2_t;

  typedef struct packed {
    base_t       b;
    vec3_t       vmag;
    logic [2:0]  vneg;
    logic [39:0] smaxsq;
    logic [39:0] sminsq;
    logic [63:0] sq;
  } dl3_t;

  typedef struct packed {
    base_t       b;
    logic [2:0]  vneg;
    logic        over;
    logic        under;
    logic        lenz;
  } dl4_t;

  typedef struct packed {
    base_t       b;
    logic [2:0]  vneg;
    logic        clamp;
  } s11_t;

  // Configuration registers.
  vec3_t       center;
  logic [16:0] decay;
  logic [30:0] tlen;
  logic [30:0] radius;
  logic [31:0] strength;

  logic adv;

  assign cfg_ready  = 1'b1;
  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      center   <= '0;
      decay    <= DECAY_RESET;
      tlen     <= TAIL_RESET;
      radius   <= RADIUS_RESET;
      strength <= STRENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER_X:      center[0] <= cfg_data;
        REG_CENTER_Y:      center[1] <= cfg_data;
        REG_CENTER_Z:      center[2] <= cfg_data;
        REG_DECAY_FACTOR:  decay     <= cfg_data[16:0];
        REG_TAIL_LENGTH:   tlen      <= cfg_data[30:0];
        REG_PULL_RADIUS:   radius    <= cfg_data[30:0];
        REG_PULL_STRENGTH: strength  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: capture the particle and its offset from the center.
  base_t in_b;
  vec3_t d_nx;
  base_t s1_b;
  vec3_t s1_d;

  always_comb begin
    in_b.vld  = item_valid;
    in_b.p    = {pos_z, pos_y, pos_x};
    in_b.v    = {vel_z, vel_y, vel_x};
    in_b.a    = {acc_z, acc_y, acc_x};
    in_b.smax = speed_max;
    in_b.smin = speed_min;
    in_b.flat = flatten;
    for (int i = 0; i < 3; i++) begin
      d_nx[i] = sat32(sx36(in_b.p[i]) - sx36(center[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_b.vld <= 1'b0;
    end else if (adv) begin
      s1_b <= in_b;
      s1_d <= d_nx;
    end
  end

  // Stage 2: squares of the offset magnitudes.
  dl1_t             s2_nx;
  dl1_t             s2;
  logic [2:0][63:0] s2_sq;
  logic [2:0][63:0] s2_sq_nx;

  always_comb begin
    s2_nx.b = s1_b;
    for (int i = 0; i < 3; i++) begin
      s2_nx.dmag[i] = mag32(s1_d[i]);
      s2_nx.dneg[i] = s1_d[i][31];
      s2_sq_nx[i]   = 64'(s2_nx.dmag[i]) * 64'(s2_nx.dmag[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.b.vld <= 1'b0;
    end else if (adv) begin
      s2    <= s2_nx;
      s2_sq <= s2_sq_nx;
    end
  end

  // Stage 3: squared distance.
  dl1_t        s3;
  logic [63:0] s3_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.b.vld <= 1'b0;
    end else if (adv) begin
      s3     <= s2;
      s3_sum <= s2_sq[0] + s2_sq[1] + s2_sq[2];
    end
  end

  // Distance root, with the particle delayed alongside.
  logic [31:0] dist_root;
  dl1_t        dl1 [0:SQRT_STEPS-1];

  pmu_sqrt u_sqrt_dist (
    .clk      (clk),
    .en       (adv),
    .radicand (s3_sum),
    .root     (dist_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQRT_STEPS; k++) dl1[k].b.vld <= 1'b0;
    end else if (adv) begin
      dl1[0] <= s3;
      for (int k = 1; k < SQRT_STEPS; k++) dl1[k] <= dl1[k-1];
    end
  end

  // Stage 4: pull gain product over the excess distance.
  dl1_t        s4;
  logic [31:0] s4_dist;
  logic        s4_pull;
  logic [63:0] s4_gprod;
  logic [31:0] excess;

  assign excess = dist_root - {1'b0, radius};

  always_ff @(posedge clk) begin
    if (rst) begin
      s4.b.vld <= 1'b0;
    end else if (adv) begin
      s4       <= dl1[SQRT_STEPS-1];
      s4_dist  <= dist_root;
      s4_pull  <= dist_root > {1'b0, radius};
      s4_gprod <= 64'(excess) * 64'(strength);
    end
  end

  // Stage 5: per-axis pull numerators.
  dl2_t             s5;
  logic [2:0][63:0] s5_divd;
  logic [31:0]      s5_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5.b.vld <= 1'b0;
    end else if (adv) begin
      s5.b    <= s4.b;
      s5.dneg <= s4.dneg;
      s5.pull <= s4_pull;
      s5_dist <= s4_dist;
      for (int i = 0; i < 3; i++) begin
        s5_divd[i] <= 64'(s4.dmag[i]) * 64'(s4_gprod[63:32]);
      end
    end
  end

  // Pull components divided by the distance.
  vec3_t pull_m;
  dl2_t  dl2 [0:DIV_STEPS-1];

  for (genvar g = 0; g < 3; g++) begin : g_pull_div
    pmu_div u_div (
      .clk      (clk),
      .en       (adv),
      .dividend (s5_divd[g]),
      .divisor  (s5_dist),
      .quotient (pull_m[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STEPS; k++) dl2[k].b.vld <= 1'b0;
    end else if (adv) begin
      dl2[0] <= s5;
      for (int k = 1; k < DIV_STEPS; k++) dl2[k] <= dl2[k-1];
    end
  end

  // Stage 6: velocity loses the outward pull.
  base_t s6_nx;
  base_t s6;

  always_comb begin
    s6_nx = dl2[DIV_STEPS-1].b;
    if (dl2[DIV_STEPS-1].pull) begin
      for (int i = 0; i < 3; i++) begin
        s6_nx.v[i] = sat32(sx36(dl2[DIV_STEPS-1].b.v[i])
                           - signed_mag(dl2[DIV_STEPS-1].dneg[i], {1'b0, pull_m[i]}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6.vld <= 1'b0;
    end else if (adv) begin
      s6 <= s6_nx;
    end
  end

  // Stage 7: add acceleration; flatten drops its z.
  base_t s7_nx;
  base_t s7;
  vec3_t acc_eff;

  always_comb begin
    s7_nx   = s6;
    acc_eff = s6.a;
    if (s6.flat) acc_eff[2] = '0;
    for (int i = 0; i < 3; i++) begin
      s7_nx.v[i] = sat32(sx36(s6.v[i]) + sx36(acc_eff[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7.vld <= 1'b0;
    end else if (adv) begin
      s7 <= s7_nx;
    end
  end

  // Stage 8: squares of speed components and of the limits.
  dl3_t             s8_nx;
  dl3_t             s8;
  logic [2:0][63:0] s8_vsq;
  logic [2:0][63:0] s8_vsq_nx;

  always_comb begin
    s8_nx.b      = s7;
    s8_nx.smaxsq = 40'(s7.smax) * 40'(s7.smax);
    s8_nx.sminsq = 40'(s7.smin) * 40'(s7.smin);
    s8_nx.sq     = '0;
    for (int i = 0; i < 3; i++) begin
      s8_nx.vmag[i] = mag32(s7.v[i]);
      s8_nx.vneg[i] = s7.v[i][31];
      s8_vsq_nx[i]  = 64'(s8_nx.vmag[i]) * 64'(s8_nx.vmag[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s8.b.vld <= 1'b0;
    end else if (adv) begin
      s8     <= s8_nx;
      s8_vsq <= s8_vsq_nx;
    end
  end

  // Stage 9: squared speed.
  dl3_t s9_nx;
  dl3_t s9;

  always_comb begin
    s9_nx    = s8;
    s9_nx.sq = s8_vsq[0] + s8_vsq[1] + s8_vsq[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s9.b.vld <= 1'b0;
    end else if (adv) begin
      s9 <= s9_nx;
    end
  end

  // Speed root, with the particle delayed alongside.
  logic [31:0] len;
  dl3_t        dl3 [0:SQRT_STEPS-1];

  pmu_sqrt u_sqrt_speed (
    .clk      (clk),
    .en       (adv),
    .radicand (s9.sq),
    .root     (len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQRT_STEPS; k++) dl3[k].b.vld <= 1'b0;
    end else if (adv) begin
      dl3[0] <= s9;
      for (int k = 1; k < SQRT_STEPS; k++) dl3[k] <= dl3[k-1];
    end
  end

  // Stage 10: limit tests and unit vector numerators.
  dl4_t             s10;
  logic [2:0][63:0] s10_divd;
  logic [31:0]      s10_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10.b.vld <= 1'b0;
    end else if (adv) begin
      s10.b     <= dl3[SQRT_STEPS-1].b;
      s10.vneg  <= dl3[SQRT_STEPS-1].vneg;
      s10.over  <= dl3[SQRT_STEPS-1].sq > {24'd0, dl3[SQRT_STEPS-1].smaxsq};
      s10.under <= dl3[SQRT_STEPS-1].sq < {24'd0, dl3[SQRT_STEPS-1].sminsq};
      s10.lenz  <= len == 32'd0;
      s10_len   <= len;
      for (int i = 0; i < 3; i++) begin
        s10_divd[i] <= {16'd0, dl3[SQRT_STEPS-1].vmag[i], 16'd0};
      end
    end
  end

  // Unit velocity magnitudes.
  vec3_t unit_q;
  dl4_t  dl4 [0:DIV_STEPS-1];

  for (genvar g = 0; g < 3; g++) begin : g_unit_div
    pmu_div u_div (
      .clk      (clk),
      .en       (adv),
      .dividend (s10_divd[g]),
      .divisor  (s10_len),
      .quotient (unit_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STEPS; k++) dl4[k].b.vld <= 1'b0;
    end else if (adv) begin
      dl4[0] <= s10;
      for (int k = 1; k < DIV_STEPS; k++) dl4[k] <= dl4[k-1];
    end
  end

  // Stage 11: clamp and tail offset products on the unit vector.
  s11_t             s11;
  logic [2:0][36:0] s11_cprod;
  logic [2:0][47:0] s11_tprod;
  logic [2:0][16:0] unit_n;
  logic [19:0]      limit;

  always_comb begin
    limit = dl4[DIV_STEPS-1].over ? dl4[DIV_STEPS-1].b.smax : dl4[DIV_STEPS-1].b.smin;
    for (int i = 0; i < 3; i++) begin
      unit_n[i] = dl4[DIV_STEPS-1].lenz ? 17'd0 : unit_q[i][16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s11.b.vld <= 1'b0;
    end else if (adv) begin
      s11.b     <= dl4[DIV_STEPS-1].b;
      s11.vneg  <= dl4[DIV_STEPS-1].vneg;
      s11.clamp <= dl4[DIV_STEPS-1].over || dl4[DIV_STEPS-1].under;
      for (int i = 0; i < 3; i++) begin
        s11_cprod[i] <= 37'(unit_n[i]) * 37'(limit);
        s11_tprod[i] <= 48'(unit_n[i]) * 48'(tlen);
      end
    end
  end

  // Stage 12: clamped velocity and the moved position.
  base_t      s12_nx;
  base_t      s12;
  vec3_t      s12_np;
  vec3_t      s12_np_nx;
  vec3_t      s12_toff;
  logic [2:0] s12_vneg;

  always_comb begin
    s12_nx = s11.b;
    for (int i = 0; i < 3; i++) begin
      if (s11.clamp) begin
        s12_nx.v[i] = sat32(signed_mag(s11.vneg[i], {12'd0, s11_cprod[i][36:16]}));
      end
      s12_np_nx[i] = sat32(sx36(s11.b.p[i]) + sx36(s12_nx.v[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s12.vld <= 1'b0;
    end else if (adv) begin
      s12      <= s12_nx;
      s12_np   <= s12_np_nx;
      s12_vneg <= s11.vneg;
      for (int i = 0; i < 3; i++) s12_toff[i] <= s11_tprod[i][47:16];
    end
  end

  // Stage 13: tail point and decay product.
  logic             s13_vld;
  logic             s13_flat;
  vec3_t            s13_np;
  vec3_t            s13_tl;
  logic [2:0][48:0] s13_dprod;
  logic [2:0]       s13_vfneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s13_vld <= 1'b0;
    end else if (adv) begin
      s13_vld  <= s12.vld;
      s13_flat <= s12.flat;
      s13_np   <= s12_np;
      for (int i = 0; i < 3; i++) begin
        s13_tl[i]    <= sat32(sx36(s12_np[i])
                              - signed_mag(s12_vneg[i], {1'b0, s12_toff[i]}));
        s13_dprod[i] <= 49'(mag32(s12.v[i])) * 49'(decay);
        s13_vfneg[i] <= s12.v[i][31];
      end
    end
  end

  // Stage 14: result register; flatten zeroes the position z.
  vec3_t out_np;
  vec3_t out_ov;
  vec3_t out_tl;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s13_vld;
      out_np       <= {s13_flat ? 32'd0 : s13_np[2], s13_np[1], s13_np[0]};
      out_tl       <= s13_tl;
      for (int i = 0; i < 3; i++) begin
        out_ov[i] <= sat32(signed_mag(s13_vfneg[i], s13_dprod[i][48:16]));
      end
    end
  end

  assign new_pos_x = out_np[0];
  assign new_pos_y = out_np[1];
  assign new_pos_z = out_np[2];
  assign new_vel_x = out_ov[0];
  assign new_vel_y = out_ov[1];
  assign new_vel_z = out_ov[2];
  assign tail_x    = out_tl[0];
  assign tail_y    = out_tl[1];
  assign tail_z    = out_tl[2];

  // An accepted transaction lands in the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> s1_b.vld)
    else $error("accepted transaction did not enter the pipeline");

  // A held pipeline keeps the particle in stage 7 in place.
  a_hold_mid: assert property (@(posedge clk) disable iff (rst)
    !adv && s7.vld |=> s7.vld && $stable(s7.v))
    else $error("mid-pipeline stage changed while held");

  // The unit vector never exceeds one in any component.
  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    dl4[DIV_STEPS-1].b.vld && !dl4[DIV_STEPS-1].lenz |->
      unit_q[0] <= 32'd65536 && unit_q[1] <= 32'd65536 && unit_q[2] <= 32'd65536)
    else $error("unit velocity component above one");

  // A new result only appears behind a valid last stage.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s13_vld))
    else $error("result appeared without a particle behind it");

endmodule

[sv/pmu_sqrt.sv]
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// Depends on pmu_pkg for the stage count.
module pmu_sqrt import pmu_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  logic [63:0] x_q   [0:SQRT_STEPS-1];
  logic [63:0] r_q   [0:SQRT_STEPS-1];
  logic [63:0] x_in  [0:SQRT_STEPS-1];
  logic [63:0] r_in  [0:SQRT_STEPS-1];
  logic [63:0] x_nx  [0:SQRT_STEPS-1];
  logic [63:0] r_nx  [0:SQRT_STEPS-1];
  logic [63:0] one_b [0:SQRT_STEPS-1];
  logic [63:0] trial [0:SQRT_STEPS-1];

  // Each stage tries one more root bit and keeps the remainder.
  always_comb begin
    x_in[0] = radicand;
    r_in[0] = '0;
    for (int k = 1; k < SQRT_STEPS; k++) begin
      x_in[k] = x_q[k-1];
      r_in[k] = r_q[k-1];
    end
    for (int k = 0; k < SQRT_STEPS; k++) begin
      one_b[k] = 64'd1 << (2 * (SQRT_STEPS - 1 - k));
      trial[k] = r_in[k] + one_b[k];
      if (x_in[k] >= trial[k]) begin
        x_nx[k] = x_in[k] - trial[k];
        r_nx[k] = (r_in[k] >> 1) + one_b[k];
      end else begin
        x_nx[k] = x_in[k];
        r_nx[k] = r_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        x_q[k] <= x_nx[k];
        r_q[k] <= r_nx[k];
      end
    end
  end

  assign root = r_q[SQRT_STEPS-1][31:0];

endmodule

[sv/pmu_div.sv]
// Pipelined restoring divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per stage; the quotient must fit in 32 bits. Uses pmu_pkg.
module pmu_div import pmu_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient
);

  logic [31:0] rem_q [0:DIV_STEPS-1];
  logic [31:0] lo_q  [0:DIV_STEPS-1];
  logic [31:0] quo_q [0:DIV_STEPS-1];
  logic [31:0] den_q [0:DIV_STEPS-1];
  logic [31:0] rem_in [0:DIV_STEPS-1];
  logic [31:0] lo_in  [0:DIV_STEPS-1];
  logic [31:0] quo_in [0:DIV_STEPS-1];
  logic [31:0] den_in [0:DIV_STEPS-1];
  logic [32:0] part   [0:DIV_STEPS-1];
  logic [32:0] diff   [0:DIV_STEPS-1];
  logic        fits   [0:DIV_STEPS-1];

  // The upper half starts as the partial remainder; each stage brings down
  // one low dividend bit and subtracts the divisor when it fits.
  always_comb begin
    rem_in[0] = dividend[63:32];
    lo_in[0]  = dividend[31:0];
    quo_in[0] = '0;
    den_in[0] = divisor;
    for (int k = 1; k < DIV_STEPS; k++) begin
      rem_in[k] = rem_q[k-1];
      lo_in[k]  = lo_q[k-1];
      quo_in[k] = quo_q[k-1];
      den_in[k] = den_q[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      part[k] = {rem_in[k], lo_in[k][31]};
      diff[k] = part[k] - {1'b0, den_in[k]};
      fits[k] = part[k] >= {1'b0, den_in[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_q[k] <= fits[k] ? diff[k][31:0] : part[k][31:0];
        lo_q[k]  <= {lo_in[k][30:0], 1'b0};
        quo_q[k] <= {quo_in[k][30:0], fits[k]};
        den_q[k] <= den_in[k];
      end
    end
  end

  assign quotient = quo_q[DIV_STEPS-1];

endmodule
